[hdl/timed_event_slot_table_unit_macros.svh]
// Assertion macros for the timed event slot table top level.
`ifndef TIMED_EVENT_SLOT_TABLE_UNIT_MACROS_SVH
`define TIMED_EVENT_SLOT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tes_pkg.sv]
// Shared types and codes for the timed event slot table.
package tes_pkg;

  // Result kind codes
  localparam logic [1:0] KIND_SCHED = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_IDLE  = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SSCAN,
    ST_SDONE,
    ST_TSCAN,
    ST_TFIN
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       capture;
    logic       idx_clr;
    logic       idx_inc;
    logic       sched_end;
    logic       busy_clr;
    logic       held_clr;
    logic       held_load;
    logic       out_load;
    logic [1:0] out_kind;
    logic       out_last;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_tick;
    logic slot_busy;
    logic due;
    logic idx_last;
    logic held_valid;
    logic out_free;
  } sts_t;

endpackage

[hdl/timed_event_slot_table_unit.sv]
// Timed event slot table: top level with controller, datapath and checks.
//
// Input channel (in_valid/in_ready) takes one beat per command. A schedule
// beat (command 0) stores sound_code, address_flag and play_time in the
// lowest free slot; a tick beat (command 1) fires every busy slot whose
// due time is below now_time, in slot order, and frees it.
// Output channel (out_valid/out_ready) returns one beat for a schedule
// (kind 0, accepted), one beat per fired slot (kind 1) or one empty beat
// (kind 2) for a tick; last marks the final beat of each command.
// One command is worked on at a time; in_ready is high only between them.
// A tick walks all SLOTS slots, one per cycle from the slot memory read port
// unless frozen as below. Each fired event waits in a one-entry hold stage
// so the last flag is known before it is sent.
// A stalled receiver freezes the slot walk when a second event is due.
// Reset empties every slot and the result register; no clearing pass.
module timed_event_slot_table_unit import tes_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [3:0]  sound_code,
  input  logic        address_flag,
  input  logic [31:0] play_time,
  input  logic [31:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        accepted,
  output logic [3:0]  fired_code,
  output logic        fired_flag,
  output logic        last
);

  `include "timed_event_slot_table_unit_macros.svh"

  cmd_t cmd;
  sts_t sts;

  tes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tes_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .command      (command),
    .sound_code   (sound_code),
    .address_flag (address_flag),
    .play_time    (play_time),
    .now_time     (now_time),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .accepted     (accepted),
    .fired_code   (fired_code),
    .fired_flag   (fired_flag),
    .last         (last)
  );

  // Checks
  `TES_ASSERT_NOW(a_load_when_free, cmd.out_load, (!out_valid || out_ready), "result overwritten")
  `TES_ASSERT_NEXT(a_busy_after_accept, (in_valid && in_ready), !in_ready, "beat accepted while busy")
  `TES_ASSERT_NOW(a_single_is_last, (out_valid && (kind != KIND_FIRED)), last, "single beat not last")

endmodule

[hdl/tes_ctrl.sv]
// Controller state machine for the timed event slot table.
module tes_ctrl import tes_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    cmd.out_kind = KIND_SCHED;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture  = 1'b1;
          cmd.idx_clr  = 1'b1;
          cmd.held_clr = 1'b1;
          state_next   = sts.in_tick ? ST_TSCAN : ST_SSCAN;
        end
      end
      // find the lowest free slot, one slot a cycle
      ST_SSCAN: begin
        if (!sts.slot_busy || sts.idx_last) begin
          cmd.sched_end = 1'b1;
          state_next    = ST_SDONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_SDONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_SCHED;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      // walk all slots; a due slot is held back one beat so last can be set
      ST_TSCAN: begin
        if (sts.due && sts.held_valid && !sts.out_free) begin
          state_next = ST_TSCAN;
        end else begin
          if (sts.due) begin
            cmd.busy_clr  = 1'b1;
            cmd.held_load = 1'b1;
            if (sts.held_valid) begin
              cmd.out_load = 1'b1;
              cmd.out_kind = KIND_FIRED;
            end
          end
          if (sts.idx_last) begin
            state_next = ST_TFIN;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      ST_TFIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = sts.held_valid ? KIND_FIRED : KIND_IDLE;
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/tes_dpath.sv]
// Datapath for the timed event slot table: slot storage, scan index, result register.
module tes_dpath import tes_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        command,
  input  logic [3:0]  sound_code,
  input  logic        address_flag,
  input  logic [31:0] play_time,
  input  logic [31:0] now_time,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        accepted,
  output logic [3:0]  fired_code,
  output logic        fired_flag,
  output logic        last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // captured item
  logic [3:0]  code_reg;
  logic        flag_reg;
  logic [31:0] time_reg;

  // scan index
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;

  // slot storage
  logic [SLOTS-1:0] busy;
  logic [3:0]       code_mem [SLOTS];
  logic             flag_mem [SLOTS];
  logic [31:0]      time_mem [SLOTS];
  logic [3:0]       rd_code;
  logic             rd_flag;
  logic [31:0]      rd_time;

  // schedule answer and held fired event
  logic       acc;
  logic       held_valid;
  logic [3:0] held_code;
  logic       held_flag;

  // Capture the beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_reg <= sound_code;
      flag_reg <= address_flag;
      time_reg <= command ? now_time : play_time;
    end
  end

  // Scan index; its next value also addresses the memory read
  always_comb begin
    if (cmd.idx_clr) begin
      idx_next = '0;
    end else if (cmd.idx_inc) begin
      idx_next = idx + IDX_W'(1);
    end else begin
      idx_next = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  // Busy bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (cmd.sched_end && !busy[idx]) begin
      busy[idx] <= 1'b1;
    end else if (cmd.busy_clr) begin
      busy[idx] <= 1'b0;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.sched_end && !busy[idx]) begin
      code_mem[idx] <= code_reg;
      flag_mem[idx] <= flag_reg;
      time_mem[idx] <= time_reg;
    end
    rd_code <= code_mem[idx_next];
    rd_flag <= flag_mem[idx_next];
    rd_time <= time_mem[idx_next];
  end

  // Schedule answer
  always_ff @(posedge clk) begin
    if (cmd.sched_end) begin
      acc <= !busy[idx];
    end
  end

  // Held fired event
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd.held_clr) begin
      held_valid <= 1'b0;
    end else if (cmd.held_load) begin
      held_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.held_load) begin
      held_code <= rd_code;
      held_flag <= rd_flag;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind       <= cmd.out_kind;
      last       <= cmd.out_last;
      accepted   <= (cmd.out_kind == KIND_SCHED) && acc;
      fired_code <= (cmd.out_kind == KIND_FIRED) ? held_code : 4'd0;
      fired_flag <= (cmd.out_kind == KIND_FIRED) && held_flag;
    end
  end

  // Status
  always_comb begin
    sts.in_tick    = command;
    sts.slot_busy  = busy[idx];
    sts.due        = busy[idx] && (rd_time < time_reg);
    sts.idx_last   = (idx == IDX_W'(SLOTS - 1));
    sts.held_valid = held_valid;
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

[verif/tb.sv]
// Self-checking testbench for the timed event slot table unit.
`timescale 1ns / 100ps

module tb;
  import tes_pkg::*;

  localparam int NSLOTS = 32;
  localparam int ITEMS = 310;
  localparam int HOLD_CYC = 400;
  localparam int MAX_SHOWN = 10;
  localparam bit CMD_SCHED = 1'b0;
  localparam bit CMD_TICK = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  code;
    logic        flag;
    logic [31:0] ptime;
    logic [31:0] ntime;
  } beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       acc;
    logic [3:0] code;
    logic       flag;
    logic       last;
  } result_t;

  // One row of the directed table; typed rows carry their own answer
  typedef struct packed {
    beat_t b;
    bit    typed;
    bit    exp_acc;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        command;
  logic [3:0]  sound_code;
  logic        address_flag;
  logic [31:0] play_time;
  logic [31:0] now_time;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic        accepted;
  logic [3:0]  fired_code;
  logic        fired_flag;
  logic        last;

  // Predicted contents of the slot table
  bit          tab_busy [NSLOTS];
  logic [3:0]  tab_code [NSLOTS];
  logic        tab_flag [NSLOTS];
  logic [31:0] tab_due  [NSLOTS];

  result_t due_results[$];     // results still owed by the block
  result_t step_results[$];    // results of the beat just accepted
  row_t    dir_rows[$];
  int      sent_cnt;
  int      err_cnt;
  int      burst_left;
  bit      hold_done;

  timed_event_slot_table_unit #(.SLOTS(NSLOTS)) u_dut (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic beat_t mk_beat(int unsigned c, int unsigned code, int unsigned flag,
                                    int unsigned pt, int unsigned nt);
    beat_t b;
    b.cmd = c[0];
    b.code = code[3:0];
    b.flag = flag[0];
    b.ptime = pt;
    b.ntime = nt;
    return b;
  endfunction

  function automatic void add_row(beat_t b, bit typed, bit acc);
    row_t r;
    r.b = b;
    r.typed = typed;
    r.exp_acc = acc;
    dir_rows.push_back(r);
  endfunction

  // Apply one beat to the predicted table, leaving its results in step_results
  function automatic void apply_to_table(beat_t b);
    int slot;
    result_t r;
    slot = -1;
    r = '0;
    r.last = 1'b1;
    if (b.cmd == CMD_SCHED) begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (!tab_busy[i] && slot < 0) slot = i;
      end
      r.kind = KIND_SCHED;
      if (slot >= 0) begin
        tab_busy[slot] = 1'b1;
        tab_code[slot] = b.code;
        tab_flag[slot] = b.flag;
        tab_due[slot] = b.ptime;
        r.acc = 1'b1;
      end
      step_results.push_back(r);
    end else begin
      // due strictly before now fires, lowest slot first
      for (int i = 0; i < NSLOTS; i++) begin
        if (tab_busy[i] && tab_due[i] < b.ntime) begin
          r.kind = KIND_FIRED;
          r.code = tab_code[i];
          r.flag = tab_flag[i];
          r.last = 1'b0;
          step_results.push_back(r);
          tab_busy[i] = 1'b0;
        end
      end
      if (step_results.size() == 0) begin
        r.kind = KIND_IDLE;
        step_results.push_back(r);
      end else begin
        step_results[step_results.size() - 1].last = 1'b1;
      end
    end
  endfunction

  // Offer one beat, wait for it to be taken, then book its results
  task automatic send_beat(beat_t b, bit typed, bit exp_acc);
    result_t r;
    @(negedge clk);
    in_valid <= 1'b1;
    command <= b.cmd;
    sound_code <= b.code;
    address_flag <= b.flag;
    play_time <= b.ptime;
    now_time <= b.ntime;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_results.delete();
    apply_to_table(b);
    if (typed) begin
      r = '0;
      r.kind = (b.cmd == CMD_TICK) ? KIND_IDLE : KIND_SCHED;
      r.acc = (b.cmd == CMD_SCHED) ? exp_acc : 1'b0;
      r.last = 1'b1;
      due_results.push_back(r);
    end else begin
      foreach (step_results[i]) due_results.push_back(step_results[i]);
    end
    sent_cnt++;
    // bursts of random length with random gaps in between
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    end
  endtask

  // Receiver: stall patterns in segments, plus one long hold-off
  initial begin
    int unsigned seg;
    int unsigned mode;
    int unsigned cyc;
    out_ready = 1'b0;
    cyc = 0;
    forever begin
      if (!hold_done && sent_cnt >= 60) begin
        hold_done = 1'b1;
        repeat (HOLD_CYC) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        mode = $urandom_range(0, 3);
        seg = $urandom_range(1, 60);
        repeat (seg) begin
          @(negedge clk);
          cyc++;
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (cyc % 3 != 0);
          endcase
        end
      end
    end
  end

  // Result checker: each beat against the oldest owed result
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got.kind = kind;
      got.acc = accepted;
      got.code = fired_code;
      got.flag = fired_flag;
      got.last = last;
      if (due_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("%0t: unexpected result kind=%0d acc=%0d code=%0d flag=%0d last=%0d",
                   $time, got.kind, got.acc, got.code, got.flag, got.last);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("%0t: mismatch exp kind=%0d acc=%0d code=%0d flag=%0d last=%0d, %s%0d %s%0d",
                     $time, want.kind, want.acc, want.code, want.flag, want.last,
                     "got kind=", got.kind, "acc=", got.acc);
          if (err_cnt <= MAX_SHOWN)
            $display("    got code=%0d flag=%0d last=%0d", got.code, got.flag, got.last);
        end
      end
    end
  end

  // Main stimulus
  initial begin
    beat_t b;
    int unsigned sel;
    int unsigned n;
    int unsigned tcur;
    bit first_seq;

    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_SCHED;
    sound_code = '0;
    address_flag = 1'b0;
    play_time = '0;
    now_time = '0;
    sent_cnt = 0;
    err_cnt = 0;
    burst_left = 0;
    hold_done = 1'b0;
    foreach (tab_busy[i]) tab_busy[i] = 1'b0;

    // directed table: empty ticks, extremes, equal times, multi-fire
    add_row(mk_beat(CMD_TICK, 0, 0, 0, 0), 1, 0);
    add_row(mk_beat(CMD_TICK, 15, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 0);
    add_row(mk_beat(CMD_SCHED, 0, 0, 0, 32'hFFFF_FFFF), 1, 1);
    add_row(mk_beat(CMD_SCHED, 15, 1, 32'hFFFF_FFFF, 0), 1, 1);
    add_row(mk_beat(CMD_SCHED, 5, 1, 100, 0), 1, 1);
    add_row(mk_beat(CMD_TICK, 0, 0, 0, 0), 1, 0);
    add_row(mk_beat(CMD_TICK, 0, 0, 0, 100), 0, 0);
    add_row(mk_beat(CMD_TICK, 0, 0, 0, 101), 0, 0);
    add_row(mk_beat(CMD_SCHED, 10, 0, 50, 0), 1, 1);
    add_row(mk_beat(CMD_SCHED, 3, 1, 10, 0), 1, 1);
    add_row(mk_beat(CMD_SCHED, 12, 1, 7, 0), 1, 1);
    add_row(mk_beat(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF), 0, 0);
    add_row(mk_beat(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF), 1, 0);
    add_row(mk_beat(CMD_SCHED, 9, 0, 32'hAAAA_AAAA, 32'h5555_5555), 1, 1);
    add_row(mk_beat(CMD_SCHED, 6, 1, 32'h5555_5555, 32'hAAAA_AAAA), 1, 1);
    add_row(mk_beat(CMD_TICK, 0, 0, 0, 32'h5555_5556), 0, 0);
    add_row(mk_beat(CMD_TICK, 0, 0, 0, 1), 1, 0);
    add_row(mk_beat(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF), 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].exp_acc);

    // random sequences; the first one overfills the table
    tcur = $urandom_range(1000, 5000);
    first_seq = 1'b1;
    while (sent_cnt < ITEMS) begin
      sel = first_seq ? 0 : $urandom_range(0, 9);
      if ($urandom_range(0, 7) == 0) tcur = $urandom;
      if (sel <= 2) begin
        n = first_seq ? 34 : $urandom_range(8, 40);
        repeat (n) begin
          b = mk_beat(CMD_SCHED, $urandom_range(0, 15), $urandom_range(0, 1),
                      tcur + $urandom_range(0, 300), $urandom);
          send_beat(b, 0, 0);
        end
        if ($urandom_range(0, 2) == 0) tcur = 32'hFFFF_FFFF;
        else tcur = tcur + $urandom_range(0, 400);
        send_beat(mk_beat(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 1),
                          $urandom, tcur), 0, 0);
      end else if (sel <= 7) begin
        n = $urandom_range(4, 20);
        repeat (n) begin
          if ($urandom_range(0, 9) < 6) begin
            b = mk_beat(CMD_SCHED, $urandom_range(0, 15), $urandom_range(0, 1),
                        tcur + $urandom_range(0, 200), $urandom);
          end else begin
            tcur = tcur + $urandom_range(0, 120);
            b = mk_beat(CMD_TICK, $urandom_range(0, 15), $urandom_range(0, 1),
                        $urandom, tcur);
          end
          send_beat(b, 0, 0);
        end
      end else begin
        n = $urandom_range(2, 8);
        repeat (n) begin
          b = mk_beat($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 1),
                      $urandom, $urandom);
          send_beat(b, 0, 0);
        end
      end
      first_seq = 1'b0;
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then allow a full slot walk for stray beats
    while (due_results.size() != 0) @(posedge clk);
    repeat (NSLOTS + 8) @(posedge clk);
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/tes_pkg.sv
hdl/tes_ctrl.sv
hdl/tes_dpath.sv
hdl/timed_event_slot_table_unit.sv
verif/tb.sv
